@@ sv/mwo_pkg.sv @@
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared constants for the multi-waveform oscillator: register indexes,
// wave mode codes, the fixed-point sine polynomial coefficients and the
// widths of the bit-serial multiplier.
// ----------------------------------------------------------------------------
package mwo_pkg;

  // Parameter defaults.
  localparam int SINE_ENTRIES_DEF = 1024;
  localparam int PERIOD_BITS_DEF  = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_WAVE_MODE      = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE      = 3'd1;
  localparam logic [2:0] REG_PHASE_STEP     = 3'd2;
  localparam logic [2:0] REG_PHASE_OFFSET   = 3'd3;
  localparam logic [2:0] REG_PERIOD_SAMPLES = 3'd4;

  // Wave modes.
  localparam logic [1:0] MODE_SINE     = 2'd0;
  localparam logic [1:0] MODE_SQUARE   = 2'd1;
  localparam logic [1:0] MODE_TRIANGLE = 2'd2;
  localparam logic [1:0] MODE_SAWTOOTH = 2'd3;

  localparam logic [14:0] FULL_SCALE = 15'd32767;
  localparam logic [14:0] AMP_RESET  = 15'd32767;

  // Multiplier operand width and the Q30 fraction position.
  localparam int MUL_W = 31;
  localparam int FRAC  = 30;

  // Odd Taylor coefficients of sin(pi/2 * x), Q30.
  localparam logic [30:0] K1  = 31'd1686629713;
  localparam logic [30:0] K3  = 31'd693598668;
  localparam logic [30:0] K5  = 31'd85569306;
  localparam logic [30:0] K7  = 31'd5026995;
  localparam logic [30:0] K9  = 31'd172272;
  localparam logic [30:0] K11 = 31'd3864;

  localparam logic [2:0] HORN_LAST = 3'd4;

  // Horner coefficient for each pass, after the K11 start value.
  function automatic logic [30:0] horner_coef(input logic [2:0] idx);
    logic [30:0] k;
    case (idx)
      3'd0:    k = K9;
      3'd1:    k = K7;
      3'd2:    k = K5;
      3'd3:    k = K3;
      default: k = K1;
    endcase
    return k;
  endfunction

endpackage

@@ sv/multi_waveform_oscillator.sv @@
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// DDS style oscillator giving one signed Q1.15 sample per input item, in sine,
// square, triangle or sawtooth form, with a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
// Usage:
//   Each item accepted on the in_ channel (in_valid & in_ready) is one tick;
//   in_restart starts the waveform over. Exactly one out_sample item follows.
//   Registers are written on the cfg_ port (cfg_we, cfg_index, cfg_wdata)
//   while no item is in flight; writes never restart the waveform.
// Datapath:
//   All products go through one shift-add multiplier, and all ratios through
//   one restoring divider that takes one dividend bit per cycle. Sine and
//   square evaluate the quarter-wave polynomial on the fly: eight products,
//   a rounding step and a division. Triangle and sawtooth need one product
//   and one division; for them a period below two goes straight from the
//   idle state to the final state.
//   One item is in work at a time; in_ready is high whenever the datapath is
//   free, even while a finished result waits in the output register.
// Reset and stalls:
//   Reset loads the register defaults and marks the next item as a fresh
//   start. If out_ready is low, the next result waits in the final state and
//   the block takes no further item until the output register drains.
//   SINE_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator import mwo_pkg::*; #(
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
  parameter int PERIOD_BITS  = PERIOD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int LOG2N  = $clog2(SINE_ENTRIES);
  localparam int PB     = PERIOD_BITS;
  localparam int RW     = PB + 1;
  localparam int NW     = PB + 2;
  localparam int DEN_W  = (PB > 15) ? PB : 15;
  localparam int DVD_W  = ((15 + PB) > 30) ? (15 + PB) : 30;
  localparam int CNT_MX = (DVD_W > MUL_W) ? DVD_W : MUL_W;
  localparam int CNT_W  = $clog2(CNT_MX);
  localparam int PW     = 2 * MUL_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_MPOST = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [2:0] OP_SQ   = 3'd0;
  localparam logic [2:0] OP_HORN = 3'd1;
  localparam logic [2:0] OP_XT   = 3'd2;
  localparam logic [2:0] OP_RND  = 3'd3;
  localparam logic [2:0] OP_AMP  = 3'd4;

  // Configuration and oscillator state.
  logic [1:0]       wave_mode_r, wave_mode_nxt;
  logic [14:0]      amplitude_r, amplitude_nxt;
  logic [31:0]      phase_step_r, phase_step_nxt;
  logic [31:0]      phase_offset_r, phase_offset_nxt;
  logic [PB-1:0]    period_r, period_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [RW-1:0]    ramp_r, ramp_nxt;
  logic             fresh_r, fresh_nxt;

  // Sequencer and datapath.
  logic [2:0]       st_r, st_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [2:0]       hc_r, hc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MUL_W-1:0] x_r, x_nxt;
  logic [MUL_W-1:0] y_r, y_nxt;
  logic [MUL_W-1:0] mc_r, mc_nxt;
  logic [PW-1:0]    pr_r, pr_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic             neg_r, neg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_sample_r, out_sample_nxt;

  // Per-tick combinational terms.
  logic             is_tri, is_ramp, start_over;
  logic [RW-1:0]    half, limit, ramp_eff, j, j_inc;
  logic [31:0]      acc_eff, phase;
  logic [LOG2N-1:0] sidx;
  logic [LOG2N:0]   k;
  logic [NW-1:0]    two_j, half_n, three_half, pm1, pos, negt, num_mag;
  logic             num_neg;
  logic [MUL_W:0]   mul_sum;
  logic [MUL_W-1:0] mul_hi;
  logic [MUL_W-1:0] t_new;
  logic [47:0]      rnd;
  logic [14:0]      sine_mag;
  logic [DEN_W:0]   trial;
  logic             q_bit;
  logic [14:0]      quot, mag;
  logic [15:0]      mag16;

  assign in_ready   = (st_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  always_comb begin
    is_tri  = (wave_mode_r == MODE_TRIANGLE);
    is_ramp = is_tri || (wave_mode_r == MODE_SAWTOOTH);
    half    = RW'(period_r >> 1);
    limit   = is_tri ? (half << 1) : RW'(period_r);

    start_over = fresh_r || in_restart;
    acc_eff    = start_over ? 32'd0 : acc_r;
    if (start_over) begin
      ramp_eff = is_tri ? (half >> 1) : '0;
    end else begin
      ramp_eff = ramp_r;
    end

    // Ramp position after the out-of-range check, and its successor.
    j     = (ramp_eff >= limit) ? '0 : ramp_eff;
    j_inc = j + RW'(1);

    two_j      = {j, 1'b0};
    half_n     = NW'(half);
    three_half = half_n + (half_n << 1);
    pm1        = NW'(period_r) - NW'(1);
    if (!is_tri) begin
      pos  = pm1;
      negt = two_j;
    end else if (j < half) begin
      pos  = two_j;
      negt = half_n;
    end else begin
      pos  = three_half;
      negt = two_j;
    end
    num_neg = (negt > pos);
    num_mag = num_neg ? (negt - pos) : (pos - negt);

    // Quarter-wave table index; odd quadrants read the table backwards.
    phase = acc_eff + phase_offset_r;
    sidx  = phase[29 -: LOG2N];
    k     = phase[30] ? ((LOG2N + 1)'(SINE_ENTRIES) - {1'b0, sidx}) : {1'b0, sidx};

    mul_hi  = pr_r[PW-1:MUL_W];
    mul_sum = {1'b0, mul_hi} + (pr_r[0] ? {1'b0, mc_r} : '0);
    t_new   = horner_coef(hc_r) - pr_r[FRAC +: MUL_W];

    rnd = pr_r[47:0] + 48'(32'd1 << 29);
    if (rnd[46:30] > 17'(FULL_SCALE)) begin
      sine_mag = FULL_SCALE;
    end else begin
      sine_mag = rnd[44:30];
    end

    trial = {rem_r, dq_r[DVD_W-1]};
    q_bit = (trial >= {1'b0, den_r});

    quot  = dq_r[14:0];
    mag   = (wave_mode_r == MODE_SQUARE) ? amplitude_r : quot;
    mag16 = {1'b0, mag};
  end

  always_comb begin
    wave_mode_nxt    = wave_mode_r;
    amplitude_nxt    = amplitude_r;
    phase_step_nxt   = phase_step_r;
    phase_offset_nxt = phase_offset_r;
    period_nxt       = period_r;
    acc_nxt          = acc_r;
    ramp_nxt         = ramp_r;
    fresh_nxt        = fresh_r;
    st_nxt           = st_r;
    op_nxt           = op_r;
    hc_nxt           = hc_r;
    cnt_nxt          = cnt_r;
    x_nxt            = x_r;
    y_nxt            = y_r;
    mc_nxt           = mc_r;
    pr_nxt           = pr_r;
    rem_nxt          = rem_r;
    den_nxt          = den_r;
    dq_nxt           = dq_r;
    neg_nxt          = neg_r;
    out_valid_nxt    = out_valid_r;
    out_sample_nxt   = out_sample_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_MODE:      wave_mode_nxt    = cfg_wdata[1:0];
        REG_AMPLITUDE:      amplitude_nxt    = cfg_wdata[14:0];
        REG_PHASE_STEP:     phase_step_nxt   = cfg_wdata;
        REG_PHASE_OFFSET:   phase_offset_nxt = cfg_wdata;
        REG_PERIOD_SAMPLES: period_nxt       = cfg_wdata[PB-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          fresh_nxt = 1'b0;
          acc_nxt   = acc_eff + phase_step_r;
          cnt_nxt   = '0;
          if (!is_ramp) begin
            ramp_nxt = ramp_eff;
            x_nxt    = MUL_W'({k, (FRAC - LOG2N)'(0)});
            mc_nxt   = MUL_W'({k, (FRAC - LOG2N)'(0)});
            pr_nxt   = PW'({k, (FRAC - LOG2N)'(0)});
            op_nxt   = OP_SQ;
            neg_nxt  = phase[31];
            den_nxt  = DEN_W'(FULL_SCALE);
            st_nxt   = S_MUL;
          end else if (period_r < PB'(2)) begin
            ramp_nxt = '0;
            dq_nxt   = '0;
            neg_nxt  = 1'b0;
            st_nxt   = S_FIN;
          end else begin
            ramp_nxt = (j_inc >= limit) ? '0 : j_inc;
            mc_nxt   = MUL_W'(num_mag);
            pr_nxt   = PW'(amplitude_r);
            op_nxt   = OP_AMP;
            neg_nxt  = num_neg;
            den_nxt  = is_tri ? DEN_W'(half) : DEN_W'(pm1);
            st_nxt   = S_MUL;
          end
        end
      end

      S_MUL: begin
        pr_nxt  = {mul_sum, pr_r[MUL_W-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL_W - 1)) begin
          st_nxt = S_MPOST;
        end
      end

      S_MPOST: begin
        cnt_nxt = '0;
        case (op_r)
          OP_SQ: begin
            y_nxt  = pr_r[FRAC +: MUL_W];
            mc_nxt = pr_r[FRAC +: MUL_W];
            pr_nxt = PW'(K11);
            hc_nxt = '0;
            op_nxt = OP_HORN;
            st_nxt = S_MUL;
          end
          OP_HORN: begin
            pr_nxt = PW'(t_new);
            st_nxt = S_MUL;
            if (hc_r == HORN_LAST) begin
              mc_nxt = x_r;
              op_nxt = OP_XT;
            end else begin
              mc_nxt = y_r;
              hc_nxt = hc_r + 3'd1;
            end
          end
          OP_XT: begin
            // Scale the Q30 sine by full scale: s * 32767 = (s << 15) - s.
            pr_nxt = PW'({pr_r[FRAC +: MUL_W], 15'd0}) - PW'(pr_r[FRAC +: MUL_W]);
            op_nxt = OP_RND;
          end
          OP_RND: begin
            mc_nxt = MUL_W'(sine_mag);
            pr_nxt = PW'(amplitude_r);
            op_nxt = OP_AMP;
            st_nxt = S_MUL;
          end
          OP_AMP: begin
            dq_nxt  = pr_r[DVD_W-1:0];
            rem_nxt = '0;
            st_nxt  = S_DIV;
          end
          default: st_nxt = S_IDLE;
        endcase
      end

      S_DIV: begin
        rem_nxt = q_bit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        dq_nxt  = {dq_r[DVD_W-2:0], q_bit};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          st_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = (neg_r && (quot != '0)) ? (16'd0 - mag16) : mag16;
          st_nxt         = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_mode_r    <= MODE_SINE;
      amplitude_r    <= AMP_RESET;
      phase_step_r   <= '0;
      phase_offset_r <= '0;
      period_r       <= PB'(100);
      acc_r          <= '0;
      ramp_r         <= '0;
      fresh_r        <= 1'b1;
      st_r           <= S_IDLE;
      out_valid_r    <= 1'b0;
    end else begin
      wave_mode_r    <= wave_mode_nxt;
      amplitude_r    <= amplitude_nxt;
      phase_step_r   <= phase_step_nxt;
      phase_offset_r <= phase_offset_nxt;
      period_r       <= period_nxt;
      acc_r          <= acc_nxt;
      ramp_r         <= ramp_nxt;
      fresh_r        <= fresh_nxt;
      st_r           <= st_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    hc_r         <= hc_nxt;
    cnt_r        <= cnt_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    mc_r         <= mc_nxt;
    pr_r         <= pr_nxt;
    rem_r        <= rem_nxt;
    den_r        <= den_nxt;
    dq_r         <= dq_nxt;
    neg_r        <= neg_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // A finished sample that finds the output register free is shown next cycle.
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && (!out_valid_r || out_ready)) |=> (out_valid_r && st_r == S_IDLE))
    else $error("finished sample not loaded into output register");

  // The restoring divider keeps its partial remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (den_r != '0 && rem_r < den_r))
    else $error("divider remainder out of range");

  // Every ratio is at most the amplitude, so the quotient fits in 15 bits.
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN) |-> (dq_r[DVD_W-1:15] == '0))
    else $error("quotient exceeds sample range");

  // While a ramp item is in work the stored position is inside the period.
  a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE && is_ramp) |-> (ramp_r < limit || ramp_r == '0))
    else $error("ramp position outside its period");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-waveform oscillator. Every tick item that
// is sent is run through a local copy of the oscillator's phase and ramp state
// to predict its sample. Results are compared in order as they drain. Directed
// tests cover each wave mode and its corner cases, then random traffic
// reconfigures the block between bursts under three idling patterns.
// ----------------------------------------------------------------------------
module tb_top import mwo_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int RANDOM_TICKS   = 120;

  localparam longint SINE_SIZE = SINE_ENTRIES_DEF;
  localparam longint Q15_MAX   = 32767;
  localparam logic [2:0] FIRST_UNUSED_REG = REG_PERIOD_SAMPLES + 3'd1;

  // Q30 Taylor terms of sin(pi/2 * x).
  localparam longint TAY1  = 1686629713;
  localparam longint TAY3  = 693598668;
  localparam longint TAY5  = 85569306;
  localparam longint TAY7  = 5026995;
  localparam longint TAY9  = 172272;
  localparam longint TAY11 = 3864;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               in_restart = 1'b0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic signed [15:0] out_sample;
  logic               cfg_we     = 1'b0;
  logic [2:0]         cfg_index  = REG_WAVE_MODE;
  logic [31:0]        cfg_wdata  = '0;

  multi_waveform_oscillator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Local copy of the register file and the oscillator state.
  logic [1:0]  wave_sel;
  int unsigned peak;
  logic [31:0] phase_inc;
  logic [31:0] phase_off;
  int unsigned period_len;
  logic [31:0] tick_phase;
  longint      ramp_pos;
  bit          start_pending;

  logic signed [15:0] expected_samples[$];
  int error_count  = 0;
  int stall_cycles = 0;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int mode_ticks[4] = '{default: 0};
  int restart_ticks = 0;
  int checked_samples = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint quarter_wave(input longint k);
    longint x, y, t, s, v;
    x = (k << 30) / SINE_SIZE;
    y = (x * x) >> 30;
    t = TAY9 - ((y * TAY11) >> 30);
    t = TAY7 - ((y * t) >> 30);
    t = TAY5 - ((y * t) >> 30);
    t = TAY3 - ((y * t) >> 30);
    t = TAY1 - ((y * t) >> 30);
    s = (x * t) >> 30;
    v = (s * Q15_MAX + (longint'(1) << 29)) >> 30;
    return (v > Q15_MAX) ? Q15_MAX : v;
  endfunction

  // Advances the local oscillator by one tick and returns its sample.
  function automatic logic signed [15:0] next_sample(input bit restart);
    longint half, limit, idx, k, mag, num, den, p_len;
    logic [31:0] phase;
    logic [1:0]  quad;
    bit          neg;
    p_len = period_len;
    half  = p_len / 2;
    limit = (wave_sel == MODE_TRIANGLE) ? 2 * half : p_len;
    mag   = 0;
    neg   = 1'b0;
    if (start_pending || restart) begin
      tick_phase    = '0;
      ramp_pos      = (wave_sel == MODE_TRIANGLE) ? half / 2 : 0;
      start_pending = 1'b0;
    end
    if (wave_sel == MODE_SINE || wave_sel == MODE_SQUARE) begin
      phase = tick_phase + phase_off;
      quad  = phase[31:30];
      idx   = (longint'(phase[29:0]) * SINE_SIZE) >> 30;
      k     = quad[0] ? SINE_SIZE - idx : idx;
      mag   = (longint'(peak) * quarter_wave(k)) / Q15_MAX;
      neg   = quad[1] && mag != 0;
      // Square follows the sign of the sine; a sine that truncates to zero
      // counts as positive.
      if (wave_sel == MODE_SQUARE) mag = peak;
    end else if (p_len < 2) begin
      ramp_pos = 0;
    end else begin
      // A ramp left beyond the period by a register change starts over.
      if (ramp_pos >= limit) ramp_pos = 0;
      if (wave_sel == MODE_TRIANGLE) begin
        num = (ramp_pos < half) ? 2 * ramp_pos - half : 3 * half - 2 * ramp_pos;
        den = half;
      end else begin
        num = p_len - 1 - 2 * ramp_pos;
        den = p_len - 1;
      end
      mag = (longint'(peak) * ((num < 0) ? -num : num)) / den;
      neg = num < 0 && mag != 0;
      ramp_pos++;
      if (ramp_pos >= limit) ramp_pos = 0;
    end
    tick_phase = tick_phase + phase_inc;
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    case (index)
      REG_WAVE_MODE:      wave_sel   = value[1:0];
      REG_AMPLITUDE:      peak       = value[14:0];
      REG_PHASE_STEP:     phase_inc  = value;
      REG_PHASE_OFFSET:   phase_off  = value;
      REG_PERIOD_SAMPLES: period_len = value[PERIOD_BITS_DEF-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_tick(input bit restart);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    mode_ticks[wave_sel]++;
    if (restart) restart_ticks++;
    expected_samples.push_back(next_sample(restart));
  endtask

  // Registers may only change with nothing in flight.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_sine();
    wait_idle();
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    wait_idle();
    write_reg(REG_PHASE_OFFSET, 32'hFFFF_FFFF);
    send_tick(1'b1);
    wait_idle();
    write_reg(REG_AMPLITUDE, 32'd0);
    send_tick(1'b0);
  endtask

  task automatic test_square();
    wait_idle();
    write_reg(REG_WAVE_MODE, {30'd0, MODE_SQUARE});
    write_reg(REG_AMPLITUDE, 32'd12345);
    write_reg(REG_PHASE_OFFSET, 32'd0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
  endtask

  task automatic test_triangle();
    wait_idle();
    write_reg(REG_WAVE_MODE, {30'd0, MODE_TRIANGLE});
    write_reg(REG_AMPLITUDE, 32'd32767);
    write_reg(REG_PERIOD_SAMPLES, 32'd8);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  task automatic test_sawtooth();
    wait_idle();
    write_reg(REG_WAVE_MODE, {30'd0, MODE_SAWTOOTH});
    write_reg(REG_PERIOD_SAMPLES, 32'd5);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    // Shrinking the period leaves the ramp past its end.
    wait_idle();
    write_reg(REG_PERIOD_SAMPLES, 32'd2);
    send_tick(1'b0);
  endtask

  task automatic test_short_period();
    wait_idle();
    write_reg(REG_PERIOD_SAMPLES, 32'd1);
    send_tick(1'b0);
    wait_idle();
    write_reg(REG_WAVE_MODE, {30'd0, MODE_TRIANGLE});
    write_reg(REG_PERIOD_SAMPLES, 32'd0);
    send_tick(1'b0);
  endtask

  task automatic test_register_masking();
    wait_idle();
    for (int r = FIRST_UNUSED_REG; r <= 7; r++) write_reg(3'(r), 32'hFFFF_FFFF);
    write_reg(REG_PERIOD_SAMPLES, 32'hFFFF_FFFF);
    write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
    send_tick(1'b0);
  endtask

  task automatic randomize_settings();
    logic [31:0] value;
    if ($urandom_range(2) != 0) write_reg(REG_WAVE_MODE, $urandom);
    if ($urandom_range(2) != 0) begin
      value = $urandom;
      case ($urandom_range(9))
        0:       value[14:0] = '0;
        1:       value[14:0] = '1;
        default: ;
      endcase
      write_reg(REG_AMPLITUDE, value);
    end
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(5))
        0:       value = '0;
        1:       value = '1;
        2:       value = $urandom_range(32'h0400_0000);
        default: value = $urandom;
      endcase
      write_reg(REG_PHASE_STEP, value);
    end
    if ($urandom_range(2) != 0) write_reg(REG_PHASE_OFFSET, $urandom);
    if ($urandom_range(2) != 0) begin
      value = $urandom;
      // Mostly short periods so the ramps wrap often.
      case ($urandom_range(9))
        0:       value[15:0] = 16'($urandom_range(1));
        1:       value[15:0] = '1;
        2:       ;
        default: value[15:0] = 16'($urandom_range(40, 2));
      endcase
      write_reg(REG_PERIOD_SAMPLES, value);
    end
    if ($urandom_range(7) == 0) write_reg(3'($urandom_range(7, FIRST_UNUSED_REG)), $urandom);
  endtask

  task automatic test_random_traffic(input int ticks);
    int sent, burst;
    sent = 0;
    while (sent < ticks) begin
      wait_idle();
      randomize_settings();
      burst = $urandom_range(30, 5);
      repeat (burst) send_tick($urandom_range(7) == 0);
      sent += burst;
    end
  endtask

  // Receiver: random back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          error_count++;
          $display("%0t: unexpected sample, expected none, got %0d", $time, out_sample);
        end else begin
          want = expected_samples.pop_front();
          checked_samples++;
          if (out_sample !== want) begin
            error_count++;
            $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, out_sample);
          end
        end
      end
    end
  end

  initial begin
    wave_sel      = MODE_SINE;
    peak          = AMP_RESET;
    phase_inc     = '0;
    phase_off     = '0;
    period_len    = 100;
    tick_phase    = '0;
    ramp_pos      = 0;
    start_pending = 1'b1;

    in_idle_pct  = 36;
    out_idle_pct = 63;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_sine();
    test_square();
    test_triangle();
    test_sawtooth();
    test_short_period();
    test_register_masking();

    test_random_traffic(RANDOM_TICKS);
    in_idle_pct  = 63;
    out_idle_pct = 36;
    test_random_traffic(RANDOM_TICKS);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_traffic(RANDOM_TICKS);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ticks sent: %0d sine, %0d square, %0d triangle, %0d sawtooth, %0d restarts.",
             mode_ticks[MODE_SINE], mode_ticks[MODE_SQUARE], mode_ticks[MODE_TRIANGLE],
             mode_ticks[MODE_SAWTOOTH], restart_ticks);
    $display("Samples checked: %0d, under three back-pressure patterns.", checked_samples);
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
